@@ sv/rfpp_pkg.sv @@
// ----------------------------------------------------------------------------
// rfpp_pkg
// Shared types, constants and the twiddle table for the real-FFT power
// prefix block.
// ----------------------------------------------------------------------------
package rfpp_pkg;

  // Transform sizing
  localparam int MAX_LENGTH  = 1024;
  localparam int HALF_MAX    = MAX_LENGTH / 2;
  localparam int EIGHTH_MAX  = MAX_LENGTH / 8;
  localparam int LOG2_MAX    = $clog2(MAX_LENGTH);
  localparam int STORE_AW    = $clog2(HALF_MAX);
  localparam int COUNT_W     = STORE_AW + 1;

  // Fixed-point widths
  localparam int FRAC_BITS   = 15;
  localparam int TW_W        = FRAC_BITS + 1;
  localparam int Z_W         = 24;
  localparam int PART_W      = Z_W + 1;
  localparam int X_W         = Z_W + 3;
  localparam int ACC_W       = 2 * X_W;
  localparam int SUM_W       = 64;

  // Configuration port
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int LG_W        = 4;
  localparam logic [LG_W-1:0]    LOG2_LENGTH_RESET = LG_W'(10);
  localparam logic [COUNT_W-1:0] BIN_LIMIT_RESET   = COUNT_W'(512);
  localparam logic [LG_W-1:0]    LG_MIN            = LG_W'(3);
  localparam logic [LG_W-1:0]    LG_MAX            = LG_W'(LOG2_MAX);

  // Register select (word index, taken from paddr[2])
  localparam logic REG_LOG2_LENGTH = 1'b0;
  localparam logic REG_BIN_LIMIT   = 1'b1;

  // Item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  // Input item
  typedef struct packed {
    logic                  command;
    logic [STORE_AW-1:0]   index;
    logic signed [Z_W-1:0] z_re;
    logic signed [Z_W-1:0] z_im;
  } in_t;

  // Result item
  typedef struct packed {
    logic [STORE_AW-1:0] bin;
    logic [SUM_W-1:0]    power_prefix;
    logic                last;
    logic                saturated;
  } out_t;

  // ---------------------------------------------------------------------------
  // Twiddle table: {cos, sin} of 2*pi*k/MAX_LENGTH in Q1.15, built at
  // elaboration from a Q30 Taylor series on the first octant.
  // ---------------------------------------------------------------------------
  localparam logic [63:0] Q30_ONE    = 64'd1073741824;
  localparam logic [63:0] Q30_TWO_PI = 64'd6746518852;
  localparam int          Q_SHIFT    = 30 - FRAC_BITS;

  localparam logic [7:0] SIN_DIV [7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
  localparam logic [7:0] COS_DIV [7] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};

  typedef logic [2*TW_W-1:0] twiddle_rom_t [HALF_MAX];

  // Q30 to Q1.F, round half up, clamp below one
  function automatic logic [TW_W-1:0] to_q(input logic [63:0] q30);
    logic [63:0] v;
    logic [63:0] top;
    v   = (q30 + (64'd1 << (Q_SHIFT - 1))) >> Q_SHIFT;
    top = (64'd1 << FRAC_BITS) - 64'd1;
    return (v > top) ? top[TW_W-1:0] : v[TW_W-1:0];
  endfunction

  // {cos, sin} for an angle index within the first octant
  function automatic logic [2*TW_W-1:0] octant(input int unsigned t);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] ss;
    logic [63:0] tc;
    logic [63:0] sc;
    x  = (Q30_TWO_PI * 64'(t) + 64'(MAX_LENGTH / 2)) / 64'(MAX_LENGTH);
    x2 = (x * x) >> 30;
    ts = x;
    ss = x;
    tc = Q30_ONE;
    sc = Q30_ONE;
    for (int n = 0; n < 7; n++) begin
      ts = ((ts * x2) >> 30) / 64'(SIN_DIV[n]);
      tc = ((tc * x2) >> 30) / 64'(COS_DIV[n]);
      if ((n % 2) == 0) begin
        ss = ss - ts;
        sc = sc - tc;
      end else begin
        ss = ss + ts;
        sc = sc + tc;
      end
    end
    return {to_q(sc), to_q(ss)};
  endfunction

  function automatic twiddle_rom_t build_twiddle_rom();
    twiddle_rom_t    rom;
    logic [2*TW_W-1:0] cs;
    logic [TW_W-1:0] c16;
    logic [TW_W-1:0] s16;
    for (int k = 0; k < HALF_MAX; k++) begin
      if (k <= EIGHTH_MAX) begin
        cs     = octant(32'(k));
        rom[k] = cs;
      end else if (k <= 2 * EIGHTH_MAX) begin
        cs     = octant(32'(2 * EIGHTH_MAX - k));
        c16    = cs[2*TW_W-1:TW_W];
        s16    = cs[TW_W-1:0];
        rom[k] = {s16, c16};
      end else if (k <= 3 * EIGHTH_MAX) begin
        cs     = octant(32'(k - 2 * EIGHTH_MAX));
        c16    = cs[2*TW_W-1:TW_W];
        s16    = cs[TW_W-1:0];
        rom[k] = {TW_W'(-s16), c16};
      end else begin
        cs     = octant(32'(4 * EIGHTH_MAX - k));
        c16    = cs[2*TW_W-1:TW_W];
        s16    = cs[TW_W-1:0];
        rom[k] = {TW_W'(-c16), s16};
      end
    end
    return rom;
  endfunction

  localparam twiddle_rom_t TWIDDLE_ROM = build_twiddle_rom();

endpackage

@@ sv/real_fft_power_prefix.sv @@
// ----------------------------------------------------------------------------
// real_fft_power_prefix
// Post-processing of a packed half-length complex FFT into the running
// power sum of the real spectrum, one bin per item.
// ----------------------------------------------------------------------------
// A load item writes one packed word into the spectrum store without raising
// busy; a load to index 0 also restarts the bin sequence. A next item for
// bin 0, or one arriving after the sequence has finished, also leaves busy
// low. Any other bin keeps busy high from S_READ_J through S_SUM, and a new
// item is accepted only once busy falls: two store reads plus six products
// through the single shared 27x27 multiplier, then the 64-bit saturating
// sum. The result strobe (done) is high for one cycle and the receiver
// cannot stall it; it appears in the cycle in which busy falls. Store words
// that were never loaded read back as arbitrary data.
// ----------------------------------------------------------------------------
module real_fft_power_prefix import rfpp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              start,
  output logic              busy,
  input  in_t               item,
  output logic              done,
  output out_t              result,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ_J,
    S_PREP,
    S_MAC_CR,
    S_MAC_SI,
    S_MAC_CI,
    S_MAC_SR,
    S_SQ_R,
    S_SQ_I,
    S_SUM
  } state_t;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< FRAC_BITS;

  state_t state;

  // configuration registers
  logic [LG_W-1:0]    log2_length;
  logic [COUNT_W-1:0] bin_limit;

  // sequence state
  logic [SUM_W-1:0]   running_sum;
  logic [COUNT_W-1:0] bin_counter;
  logic               sum_saturated;

  // per-bin registers
  logic [STORE_AW-1:0]      bin_q;
  logic                     last_q;
  logic [STORE_AW-1:0]      j_addr;
  logic signed [Z_W-1:0]    zk_re;
  logic signed [Z_W-1:0]    zk_im;
  logic signed [PART_W-1:0] er;
  logic signed [PART_W-1:0] ei;
  logic signed [PART_W-1:0] orr;
  logic signed [PART_W-1:0] oi;
  logic signed [X_W-1:0]    xr;
  logic signed [X_W-1:0]    xi;
  logic signed [ACC_W-1:0]  acc;

  // memories
  logic [2*Z_W-1:0]    store [HALF_MAX];
  logic [2*Z_W-1:0]    store_q;
  logic [STORE_AW-1:0] store_raddr;
  logic [2*TW_W-1:0]   rom_q;

  // decoded control
  logic                accept;
  logic                cfg_write;
  logic [LG_W-1:0]     lg_eff;
  logic [COUNT_W-1:0]  m_len;
  logic [COUNT_W-1:0]  limit;
  logic [COUNT_W-1:0]  j_full;
  logic [COUNT_W-1:0]  tw_full;
  logic [STORE_AW-1:0] tw_addr;
  logic                is_last;

  // store read words and twiddle
  logic signed [Z_W-1:0]  zq_re;
  logic signed [Z_W-1:0]  zq_im;
  logic signed [TW_W-1:0] tw_c;
  logic signed [TW_W-1:0] tw_s;

  // shared multiplier
  logic signed [X_W-1:0]   mul_a;
  logic signed [X_W-1:0]   mul_b;
  logic signed [ACC_W-1:0] product;

  // final sum
  logic [SUM_W:0] sum_ext;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  assign zq_re = store_q[2*Z_W-1:Z_W];
  assign zq_im = store_q[Z_W-1:0];
  assign tw_c  = rom_q[2*TW_W-1:TW_W];
  assign tw_s  = rom_q[TW_W-1:0];

  // register read-back
  always_comb begin
    unique case (paddr[2])
      REG_LOG2_LENGTH: prdata = DATA_W'(log2_length);
      REG_BIN_LIMIT:   prdata = DATA_W'(bin_limit);
      default:         prdata = '0;
    endcase
  end

  // clamp configuration, derive bin addresses
  always_comb begin
    if (log2_length < LG_MIN) begin
      lg_eff = LG_MIN;
    end else if (log2_length > LG_MAX) begin
      lg_eff = LG_MAX;
    end else begin
      lg_eff = log2_length;
    end
    m_len = COUNT_W'(HALF_MAX) >> (LG_MAX - lg_eff);
    if (bin_limit == '0) begin
      limit = COUNT_W'(1);
    end else if (bin_limit > m_len) begin
      limit = m_len;
    end else begin
      limit = bin_limit;
    end
    j_full  = m_len - bin_counter;
    tw_full = bin_counter << (LG_MAX - lg_eff);
    tw_addr = tw_full[STORE_AW-1:0];
    is_last = (bin_counter == (limit - COUNT_W'(1)));
  end

  // store read address: bin k while idle, mirror bin afterwards
  assign store_raddr = (state == S_IDLE) ? bin_counter[STORE_AW-1:0] : j_addr;

  // spectrum store
  always_ff @(posedge clk) begin
    if (accept && item.command == CMD_LOAD) begin
      store[item.index] <= {item.z_re, item.z_im};
    end
    store_q <= store[store_raddr];
  end

  // twiddle table, read once per bin
  always_ff @(posedge clk) begin
    if (accept && item.command == CMD_NEXT) begin
      rom_q <= TWIDDLE_ROM[tw_addr];
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_MAC_CR: begin
        mul_a = X_W'(orr);
        mul_b = X_W'(tw_c);
      end
      S_MAC_SI: begin
        mul_a = X_W'(oi);
        mul_b = X_W'(tw_s);
      end
      S_MAC_CI: begin
        mul_a = X_W'(oi);
        mul_b = X_W'(tw_c);
      end
      S_MAC_SR: begin
        mul_a = X_W'(orr);
        mul_b = X_W'(tw_s);
      end
      S_SQ_R: begin
        mul_a = xr;
        mul_b = xr;
      end
      S_SQ_I: begin
        mul_a = xi;
        mul_b = xi;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    product = mul_a * mul_b;
  end

  assign sum_ext = {1'b0, running_sum} + (SUM_W + 1)'($unsigned(acc));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      log2_length <= LOG2_LENGTH_RESET;
      bin_limit   <= BIN_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_LOG2_LENGTH: log2_length <= pwdata[LG_W-1:0];
        REG_BIN_LIMIT:   bin_limit   <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, datapath and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_sum   <= '0;
      bin_counter   <= '0;
      sum_saturated <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.command == CMD_LOAD) begin
              // load to index 0 restarts the sequence
              if (item.index == '0) begin
                running_sum   <= '0;
                bin_counter   <= '0;
                sum_saturated <= 1'b0;
              end
            end else if (bin_counter < limit) begin
              bin_counter <= bin_counter + COUNT_W'(1);
              if (bin_counter == '0) begin
                // bin 0 reports an empty prefix
                done                <= 1'b1;
                result.bin          <= '0;
                result.power_prefix <= '0;
                result.last         <= is_last;
                result.saturated    <= sum_saturated;
              end else begin
                bin_q  <= bin_counter[STORE_AW-1:0];
                last_q <= is_last;
                j_addr <= j_full[STORE_AW-1:0];
                state  <= S_READ_J;
              end
            end
          end
        end
        S_READ_J: begin
          zk_re <= zq_re;
          zk_im <= zq_im;
          state <= S_PREP;
        end
        S_PREP: begin
          // doubled even and odd parts
          er    <= PART_W'(zk_re) + PART_W'(zq_re);
          ei    <= PART_W'(zk_im) - PART_W'(zq_im);
          orr   <= PART_W'(zk_im) + PART_W'(zq_im);
          oi    <= PART_W'(zq_re) - PART_W'(zk_re);
          state <= S_MAC_CR;
        end
        S_MAC_CR: begin
          acc   <= (ACC_W'(er) <<< FRAC_BITS) + ROUND_BIAS + product;
          state <= S_MAC_SI;
        end
        S_MAC_SI: begin
          acc   <= acc + product;
          state <= S_MAC_CI;
        end
        S_MAC_CI: begin
          xr    <= acc[FRAC_BITS+1 +: X_W];
          acc   <= (ACC_W'(ei) <<< FRAC_BITS) + ROUND_BIAS + product;
          state <= S_MAC_SR;
        end
        S_MAC_SR: begin
          acc   <= acc - product;
          state <= S_SQ_R;
        end
        S_SQ_R: begin
          xi    <= acc[FRAC_BITS+1 +: X_W];
          acc   <= product;
          state <= S_SQ_I;
        end
        S_SQ_I: begin
          acc   <= acc + product;
          state <= S_SUM;
        end
        S_SUM: begin
          // saturating accumulate and emit
          done             <= 1'b1;
          result.bin       <= bin_q;
          result.last      <= last_q;
          if (sum_ext[SUM_W]) begin
            running_sum         <= '1;
            sum_saturated       <= 1'b1;
            result.power_prefix <= '1;
            result.saturated    <= 1'b1;
          end else begin
            running_sum         <= sum_ext[SUM_W-1:0];
            result.power_prefix <= sum_ext[SUM_W-1:0];
            result.saturated    <= sum_saturated;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for real_fft_power_prefix. Load items fill the
// spectrum store and next items walk the bins; an in-bench predictor
// recomputes the twiddle table, the even/odd split, the rotation and the
// saturating power sum, and every result strobe is checked field by field
// against the oldest predicted bin. Configuration is written over the
// register port between sequences while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import rfpp_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  in_t               item;
  logic              done;
  out_t              result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  real_fft_power_prefix uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic signed [Z_W-1:0] spec_re [HALF_MAX];
  logic signed [Z_W-1:0] spec_im [HALF_MAX];
  bit [HALF_MAX-1:0]     spec_written;
  int                    tw_cos [HALF_MAX];
  int                    tw_sin [HALF_MAX];
  logic [SUM_W-1:0]      power_sum;
  int unsigned           next_bin;
  bit                    sum_sat;
  logic [LG_W-1:0]       lg_reg;
  logic [9:0]            limit_reg;
  out_t                  expected_bins [$];

  int errors     = 0;
  int sent_count = 0;
  int idle_pct   = 0;
  bit start_high = 1'b0;
  int cycles     = 0;

  // ---------------------------------------------------------------------------
  // Twiddle table, rebuilt from the Q30 series on the first octant
  // ---------------------------------------------------------------------------
  function automatic int q30_to_q(input longint unsigned q30);
    longint unsigned v;
    longint unsigned top;
    v   = (q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    top = (64'd1 << FRAC_BITS) - 64'd1;
    return (v > top) ? int'(top) : int'(v);
  endfunction

  function automatic void octant_q(input longint unsigned t, output int c, output int s);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned ss;
    longint unsigned tc;
    longint unsigned sc;
    x  = (64'd6746518852 * t + 64'(MAX_LENGTH / 2)) / 64'(MAX_LENGTH);
    x2 = (x * x) >> 30;
    ts = x;
    ss = x;
    tc = 64'd1 << 30;
    sc = tc;
    for (longint unsigned n = 1; n <= 7; n++) begin
      ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
      tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) begin
        ss = ss - ts;
        sc = sc - tc;
      end else begin
        ss = ss + ts;
        sc = sc + tc;
      end
    end
    c = q30_to_q(sc);
    s = q30_to_q(ss);
  endfunction

  function automatic void build_twiddles();
    int c;
    int s;
    for (int k = 0; k < HALF_MAX; k++) begin
      if (k <= EIGHTH_MAX) begin
        octant_q(k, c, s);
        tw_cos[k] = c;
        tw_sin[k] = s;
      end else if (k <= 2 * EIGHTH_MAX) begin
        octant_q(2 * EIGHTH_MAX - k, c, s);
        tw_cos[k] = s;
        tw_sin[k] = c;
      end else if (k <= 3 * EIGHTH_MAX) begin
        octant_q(k - 2 * EIGHTH_MAX, c, s);
        tw_cos[k] = -s;
        tw_sin[k] = c;
      end else begin
        octant_q(4 * EIGHTH_MAX - k, c, s);
        tw_cos[k] = -c;
        tw_sin[k] = s;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Bin prediction
  // ---------------------------------------------------------------------------
  // half transform length for a raw log2 setting, clamped to the legal range
  function automatic int unsigned eff_half(input logic [LG_W-1:0] lg);
    int unsigned l;
    l = lg;
    if (l < 3) l = 3;
    if (l > LOG2_MAX) l = LOG2_MAX;
    return 1 << (l - 1);
  endfunction

  function automatic int unsigned clamped_limit();
    int unsigned m;
    int unsigned lim;
    m   = eff_half(lg_reg);
    lim = limit_reg;
    if (lim < 1) lim = 1;
    if (lim > m) lim = m;
    return lim;
  endfunction

  // divide by 2^(F+1), round to nearest, ties up
  function automatic longint round_half_up(input longint v);
    return (v + (longint'(1) << FRAC_BITS)) >>> (FRAC_BITS + 1);
  endfunction

  function automatic void predict_item(input in_t it);
    int unsigned m;
    int unsigned lim;
    int unsigned k;
    int unsigned j;
    int unsigned a;
    longint er;
    longint ei;
    longint orr;
    longint oi;
    longint xr;
    longint xi;
    logic [SUM_W-1:0] pw;
    out_t r;
    if (it.command == CMD_LOAD) begin
      spec_re[it.index]      = it.z_re;
      spec_im[it.index]      = it.z_im;
      spec_written[it.index] = 1'b1;
      // load to index 0 restarts the sequence
      if (it.index == '0) begin
        power_sum = '0;
        next_bin  = 0;
        sum_sat   = 1'b0;
      end
      return;
    end
    m   = eff_half(lg_reg);
    lim = clamped_limit();
    k   = next_bin;
    // sequence finished: nothing happens
    if (k >= lim) return;
    if (k > 0) begin
      j   = m - k;
      a   = k * (MAX_LENGTH / (2 * m));
      er  = longint'(spec_re[k]) + longint'(spec_re[j]);
      ei  = longint'(spec_im[k]) - longint'(spec_im[j]);
      orr = longint'(spec_im[k]) + longint'(spec_im[j]);
      oi  = longint'(spec_re[j]) - longint'(spec_re[k]);
      xr  = round_half_up((er <<< FRAC_BITS) + tw_cos[a] * orr + tw_sin[a] * oi);
      xi  = round_half_up((ei <<< FRAC_BITS) + tw_cos[a] * oi - tw_sin[a] * orr);
      pw  = xr * xr + xi * xi;
      if (power_sum > {SUM_W{1'b1}} - pw) begin
        power_sum = {SUM_W{1'b1}};
        sum_sat   = 1'b1;
      end else begin
        power_sum = power_sum + pw;
      end
    end
    r.bin          = STORE_AW'(k);
    r.power_prefix = (k == 0) ? '0 : power_sum;
    r.last         = (k == lim - 1);
    r.saturated    = sum_sat;
    expected_bins.push_back(r);
    next_bin = k + 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Item construction
  // ---------------------------------------------------------------------------
  function automatic logic signed [Z_W-1:0] rand_z();
    case ($urandom_range(7))
      0: return Z_MAX;
      1: return Z_MIN;
      2: return '0;
      3: return '1;
      4: return Z_W'($signed($urandom_range(511)) - 256);
      default: return Z_W'($urandom);
    endcase
  endfunction

  function automatic in_t load_word(input int unsigned idx,
                                    input logic signed [Z_W-1:0] re,
                                    input logic signed [Z_W-1:0] im);
    in_t it;
    it.command = CMD_LOAD;
    it.index   = STORE_AW'(idx);
    it.z_re    = re;
    it.z_im    = im;
    return it;
  endfunction

  function automatic in_t rand_load(input int unsigned idx);
    return load_word(idx, rand_z(), rand_z());
  endfunction

  // ---------------------------------------------------------------------------
  // Item channel and register port
  // ---------------------------------------------------------------------------
  task automatic send_item(input in_t it);
    // random sender gaps
    while ($urandom_range(99) < idle_pct) begin
      if (start_high) begin
        start      <= 1'b0;
        start_high = 1'b0;
      end
      @(posedge clk);
    end
    item <= it;
    if (!start_high) begin
      start      <= 1'b1;
      start_high = 1'b1;
    end
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(it);
    sent_count++;
  endtask

  // next item; loads any store word this bin reads that was never written
  task automatic send_next();
    in_t it;
    int unsigned m;
    int unsigned k;
    m = eff_half(lg_reg);
    k = next_bin;
    if (k > 0 && k < clamped_limit()) begin
      if (!spec_written[k]) send_item(rand_load(k));
      if (!spec_written[m - k]) send_item(rand_load(m - k));
    end
    it.command = CMD_NEXT;
    it.index   = STORE_AW'($urandom);
    it.z_re    = Z_W'($urandom);
    it.z_im    = Z_W'($urandom);
    send_item(it);
  endtask

  // hold off until every predicted bin has arrived and the block is quiet
  task automatic wait_drain();
    if (start_high) begin
      start      <= 1'b0;
      start_high = 1'b0;
    end
    @(posedge clk);
    while (expected_bins.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LOG2_LENGTH) lg_reg = value[LG_W-1:0];
    else limit_reg = value[9:0];
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned lg, input int unsigned lim);
    wait_drain();
    write_reg(REG_LOG2_LENGTH, DATA_W'(lg));
    write_reg(REG_BIN_LIMIT, DATA_W'(lim));
  endtask

  // restart, fill the words the bins read, then walk the bins with some noise
  task automatic run_sequence(input int unsigned lg, input int unsigned lim,
                              input int noise_pct);
    int unsigned m;
    int unsigned n;
    set_config(lg, lim);
    send_item(rand_load(0));
    m = eff_half(lg_reg);
    n = clamped_limit();
    for (int unsigned i = 1; i < m; i++) begin
      if (i < n || m - i < n) send_item(rand_load(i));
    end
    for (int unsigned b = 0; b < n + $urandom_range(2); b++) begin
      if ($urandom_range(99) < noise_pct) begin
        if ($urandom_range(2) == 0) send_item(rand_load(0));
        else send_item(rand_load($urandom_range(HALF_MAX - 1)));
      end
      send_next();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // shortest length, extreme words, finished sequence and restart
  task automatic test_short_length();
    set_config(3, 4);
    send_item(load_word(0, Z_MAX, Z_MAX));
    send_item(load_word(1, Z_MAX, Z_MIN));
    send_item(load_word(2, Z_MIN, Z_MAX));
    send_item(load_word(3, Z_MIN, Z_MIN));
    repeat (5) send_next();
    send_item(load_word(0, '0, '0));
    send_item(load_word(HALF_MAX - 1, Z_MAX, Z_MIN));
    repeat (2) send_next();
  endtask

  // longest length: bin 1 pairs with the top store word
  task automatic test_long_length();
    set_config(10, 2);
    send_item(load_word(0, Z_MIN, Z_MAX));
    send_item(load_word(1, Z_MAX, Z_MAX));
    send_item(load_word(HALF_MAX - 1, Z_MIN, Z_MIN));
    repeat (3) send_next();
  endtask

  // out-of-range register values clamp
  task automatic test_clamps();
    set_config(0, 0);
    send_item(rand_load(0));
    repeat (2) send_next();
    set_config(15, 1023);
    write_reg(REG_BIN_LIMIT, DATA_W'(3));
    send_item(rand_load(0));
    repeat (4) send_next();
  endtask

  task automatic test_random(input int pct, input int target);
    int first;
    int sel;
    int unsigned lg;
    int unsigned m;
    int unsigned lim;
    idle_pct = pct;
    first    = sent_count;
    while (sent_count - first < target) begin
      sel = $urandom_range(99);
      if (sel < 65) lg = $urandom_range(5, 3);
      else if (sel < 85) lg = $urandom_range(7, 6);
      else if (sel < 92) lg = $urandom_range(2, 0);
      else if (sel < 96) lg = $urandom_range(10, 8);
      else lg = $urandom_range(15, 11);
      m   = eff_half(LG_W'(lg));
      sel = $urandom_range(99);
      if (m > 128) lim = (sel < 15) ? 0 : $urandom_range(6, 1);
      else if (sel < 10) lim = 0;
      else if (sel < 20) lim = 1023;
      else if (sel < 30) lim = m;
      else lim = $urandom_range(m, 1);
      run_sequence(lg, lim, 8);
    end
  endtask

  // every bin of a 128-point transform
  task automatic test_full_length();
    run_sequence(7, 64, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst     <= 1'b1;
    start   <= 1'b0;
    item    <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    build_twiddles();
    for (int i = 0; i < HALF_MAX; i++) begin
      spec_re[i] = '0;
      spec_im[i] = '0;
    end
    spec_written = '0;
    power_sum    = '0;
    next_bin     = 0;
    sum_sat      = 1'b0;
    lg_reg       = LOG2_LENGTH_RESET;
    limit_reg    = BIN_LIMIT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 18;
    test_short_length();
    test_long_length();
    test_clamps();
    test_random(18, 130);
    test_random(88, 130);
    test_random(0, 130);
    test_full_length();
    wait_drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result checker
  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && done) begin
      if (expected_bins.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual bin %0d prefix %0d",
                 $time, result.bin, result.power_prefix);
      end else begin
        want = expected_bins.pop_front();
        if (result.bin !== want.bin) begin
          errors++;
          $display("%0t: bin mismatch: expected %0d actual %0d",
                   $time, want.bin, result.bin);
        end
        if (result.power_prefix !== want.power_prefix) begin
          errors++;
          $display("%0t: power_prefix mismatch (bin %0d): expected %0d actual %0d",
                   $time, want.bin, want.power_prefix, result.power_prefix);
        end
        if (result.last !== want.last) begin
          errors++;
          $display("%0t: last mismatch (bin %0d): expected %0b actual %0b",
                   $time, want.bin, want.last, result.last);
        end
        if (result.saturated !== want.saturated) begin
          errors++;
          $display("%0t: saturated mismatch (bin %0d): expected %0b actual %0b",
                   $time, want.bin, want.saturated, result.saturated);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
